/* design/tpc_pkg.sv */
// Package for the triangle maximum path counter.
// Shared widths, default parameter values and the control bundle between stages.
// No dependencies.
`default_nettype none

package tpc_pkg;

  // Fixed field widths of the block.
  localparam int SumBits      = 27;
  localparam int OutCountBits = 32;
  localparam int RowCfgBits   = 8;

  // Largest path sum; sums saturate here.
  localparam logic [SumBits-1:0] SumMax = {SumBits{1'b1}};

  // Defaults for the top-level parameters.
  localparam int DefMaxRows   = 128;
  localparam int DefValueBits = 20;
  localparam int DefCountBits = 32;

  // Flags that travel with one cell from the cell stage to the final stage.
  typedef struct packed {
    logic first_col;  // cell is the leftmost of its row
    logic last_row;   // cell lies in the last row of the triangle
    logic emit;       // cell closes the triangle and produces the result
  } tpc_ctl_t;

endpackage

`default_nettype wire

/* design/tpc_row_mem.sv */
// Row memory of the triangle maximum path counter: one write port, one read port.
// Synchronous read with write-to-read forwarding.
// Depends on nothing.
`default_nettype none

module tpc_row_mem #(
  parameter int Depth = 128,
  parameter int Width = 59
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // A read of the entry written at the same edge returns the new data.
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/tpc_cell_stage.sv */
// Cell stage of the triangle maximum path counter: position tracking and the
// per-cell best-sum and path-count update. Uses tpc_pkg; drives tpc_row_mem.
`default_nettype none

module tpc_cell_stage #(
  parameter int MaxRows   = tpc_pkg::DefMaxRows,
  parameter int ValueBits = tpc_pkg::DefValueBits,
  parameter int CountBits = tpc_pkg::DefCountBits
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             accept_i,
  input  wire logic [ValueBits-1:0]             cell_value_i,
  input  wire logic [tpc_pkg::RowCfgBits-1:0]   row_count_i,
  input  wire logic [tpc_pkg::SumBits-1:0]      rd_sum_i,
  input  wire logic [CountBits-1:0]             rd_cnt_i,
  output logic      [$clog2(MaxRows)-1:0]       raddr_o,
  output logic      [$clog2(MaxRows)-1:0]       waddr_o,
  output logic      [tpc_pkg::SumBits-1:0]      best_o,
  output logic      [CountBits-1:0]             cnt_o,
  output tpc_pkg::tpc_ctl_t                     ctl_o
);

  localparam int AddrBits = $clog2(MaxRows);
  localparam int CmpBits  = ((AddrBits > tpc_pkg::RowCfgBits) ? AddrBits
                                                                : tpc_pkg::RowCfgBits) + 1;
  localparam int SumBits  = tpc_pkg::SumBits;

  logic [AddrBits-1:0]  row_q, row_d;
  logic [AddrBits-1:0]  col_q, col_d;
  logic [SumBits-1:0]   left_sum_q, left_sum_d;
  logic [CountBits-1:0] left_cnt_q, left_cnt_d;

  logic                 has_up, has_left, last_row, end_of_row;
  logic [32:0]          value_ext;
  logic [SumBits-1:0]   value_sat;
  logic [SumBits-1:0]   up_sum, par_sum;
  logic [CountBits-1:0] up_cnt, par_cnt;
  logic [CountBits:0]   tie_cnt;
  logic [SumBits:0]     sum_wide;
  logic [SumBits-1:0]   best;
  logic [CountBits-1:0] cnt;

  always_comb begin
    value_ext = 33'(cell_value_i);
    if (value_ext > 33'(tpc_pkg::SumMax)) begin
      value_sat = tpc_pkg::SumMax;
    end else begin
      value_sat = value_ext[SumBits-1:0];
    end
  end

  assign has_up     = (col_q < row_q);
  assign has_left   = (col_q != '0);
  assign end_of_row = (col_q >= row_q);
  // A row count of zero counts as one row, one beyond the memory as the memory depth.
  assign last_row   = (row_q == AddrBits'(MaxRows - 1)) ||
                      (CmpBits'(row_count_i) <= (CmpBits'(row_q) + CmpBits'(1)));

  assign up_sum  = has_up ? rd_sum_i : '0;
  assign up_cnt  = has_up ? rd_cnt_i : '0;
  assign tie_cnt = {1'b0, left_cnt_q} + {1'b0, up_cnt};

  always_comb begin
    par_sum = up_sum;
    par_cnt = up_cnt;
    if (has_left && has_up) begin
      priority if (left_sum_q > up_sum) begin
        par_sum = left_sum_q;
        par_cnt = left_cnt_q;
      end else if (up_sum > left_sum_q) begin
        par_sum = up_sum;
        par_cnt = up_cnt;
      end else begin
        par_sum = up_sum;
        par_cnt = tie_cnt[CountBits] ? '1 : tie_cnt[CountBits-1:0];
      end
    end else if (has_left) begin
      par_sum = left_sum_q;
      par_cnt = left_cnt_q;
    end
  end

  assign sum_wide = {1'b0, par_sum} + {1'b0, value_sat};

  always_comb begin
    if (row_q == '0) begin
      best = value_sat;
      cnt  = CountBits'(1);
    end else begin
      best = (sum_wide > {1'b0, tpc_pkg::SumMax}) ? tpc_pkg::SumMax : sum_wide[SumBits-1:0];
      cnt  = par_cnt;
    end
  end

  always_comb begin
    row_d      = row_q;
    col_d      = col_q;
    left_sum_d = left_sum_q;
    left_cnt_d = left_cnt_q;
    if (accept_i) begin
      if (row_q != '0) begin
        left_sum_d = up_sum;
        left_cnt_d = up_cnt;
      end
      if (end_of_row) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + AddrBits'(1);
      end else begin
        col_d = col_q + AddrBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      left_sum_q <= '0;
      left_cnt_q <= '0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      left_sum_q <= left_sum_d;
      left_cnt_q <= left_cnt_d;
    end
  end

  // The memory is read every cycle at the column of the next cell.
  assign raddr_o = col_d;
  assign waddr_o = col_q;
  assign best_o  = best;
  assign cnt_o   = cnt;
  assign ctl_o   = '{first_col: (col_q == '0), last_row: last_row,
                     emit: (end_of_row && last_row)};

  a_col_within_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= row_q)
    else $error("column index passed the row index");

  a_wrap_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_row && last_row |=> (row_q == '0) && (col_q == '0))
    else $error("position did not return to the apex after the last cell");

endmodule

`default_nettype wire

/* design/tpc_final_stage.sv */
// Final stage of the triangle maximum path counter: running maximum over the
// last row and the result register. Uses tpc_pkg.
`default_nettype none

module tpc_final_stage #(
  parameter int CountBits = tpc_pkg::DefCountBits
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               load_i,
  input  wire logic [tpc_pkg::SumBits-1:0]        best_i,
  input  wire logic [CountBits-1:0]               cnt_i,
  input  wire tpc_pkg::tpc_ctl_t                  ctl_i,
  input  wire logic                               out_ready_i,
  output logic                                    free_o,
  output logic                                    out_valid_o,
  output logic      [tpc_pkg::OutCountBits-1:0]   path_count_o,
  output logic      [tpc_pkg::SumBits-1:0]        best_sum_o
);

  localparam int SumBits = tpc_pkg::SumBits;

  logic                              s2_valid_q, s2_valid_d;
  logic [SumBits-1:0]                s2_best_q;
  logic [CountBits-1:0]              s2_cnt_q;
  tpc_pkg::tpc_ctl_t                 s2_ctl_q;
  logic [SumBits-1:0]                fin_best_q, fin_best_d;
  logic [CountBits-1:0]              fin_cnt_q, fin_cnt_d;
  logic                              out_valid_q, out_valid_d;
  logic [tpc_pkg::OutCountBits-1:0]  out_cnt_q;
  logic [SumBits-1:0]                out_best_q;
  logic                              s2_fire, out_load;
  logic [CountBits:0]                acc_cnt;

  // Only a closing cell has to wait for the result register.
  assign s2_fire  = s2_valid_q && !(s2_ctl_q.emit && out_valid_q && !out_ready_i);
  assign out_load = s2_fire && s2_ctl_q.emit;
  assign free_o   = !s2_valid_q || s2_fire;
  assign acc_cnt  = {1'b0, fin_cnt_q} + {1'b0, s2_cnt_q};

  always_comb begin
    fin_best_d = fin_best_q;
    fin_cnt_d  = fin_cnt_q;
    if (s2_fire && s2_ctl_q.last_row) begin
      priority if (s2_ctl_q.first_col || (s2_best_q > fin_best_q)) begin
        fin_best_d = s2_best_q;
        fin_cnt_d  = s2_cnt_q;
      end else if (s2_best_q == fin_best_q) begin
        fin_cnt_d = acc_cnt[CountBits] ? '1 : acc_cnt[CountBits-1:0];
      end
    end
  end

  always_comb begin
    s2_valid_d = load_i || (s2_valid_q && !s2_fire);
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fin_best_q  <= '0;
      fin_cnt_q   <= '0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
      fin_best_q  <= fin_best_d;
      fin_cnt_q   <= fin_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s2_best_q <= best_i;
      s2_cnt_q  <= cnt_i;
      s2_ctl_q  <= ctl_i;
    end
    if (out_load) begin
      out_cnt_q  <= tpc_pkg::OutCountBits'(fin_cnt_d);
      out_best_q <= fin_best_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign path_count_o = out_cnt_q;
  assign best_sum_o   = out_best_q;

  a_stall_only_on_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !s2_fire |-> s2_ctl_q.emit && out_valid_q)
    else $error("final stage held a cell that produces no result");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_fire && s2_ctl_q.last_row |=> fin_cnt_q != '0)
    else $error("last-row path count dropped to zero");

endmodule

`default_nettype wire

/* design/triangle_max_path_counter.sv */
// Triangle maximum path counter: top level.
// Instantiates tpc_row_mem, tpc_cell_stage and tpc_final_stage; uses tpc_pkg.
//
// Usage:
//   Cells of a number triangle arrive on the input channel (in_valid_i,
//   in_ready_o, cell_value_i) one item per cell, row-major from the apex;
//   row r holds r+1 cells. After the last cell of the last row one result
//   item leaves on the output channel (out_valid_o, out_ready_i) with the
//   maximum top-to-bottom path sum (best_sum_o) and the number of paths that
//   reach it (path_count_o). Sums saturate at all ones of 27 bits, counts at
//   all ones of COUNT_BITS. A row count of zero means one row. The user must
//   write the row count through row_count_we_i / row_count_i only while the
//   block is idle; the block itself does not enforce this.
// Rate and result path:
//   One item per cycle while in_ready_o is high; each cell does one read and
//   one write of the row memory, whose single read and write ports set that
//   rate. A closing cell passes the final-stage and result registers in turn.
// Reset and stalls:
//   Reset returns the position to the apex and sets the row count to one;
//   the row memory keeps no reset and is written before it is read. While a
//   result waits for out_ready_i, cells of the next triangle keep coming in;
//   only a second closing cell is held back until the waiting result leaves.
`default_nettype none

module triangle_max_path_counter #(
  parameter int MAX_ROWS   = tpc_pkg::DefMaxRows,
  parameter int VALUE_BITS = tpc_pkg::DefValueBits,
  parameter int COUNT_BITS = tpc_pkg::DefCountBits
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               row_count_we_i,
  input  wire logic [tpc_pkg::RowCfgBits-1:0]     row_count_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [VALUE_BITS-1:0]              cell_value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic      [tpc_pkg::OutCountBits-1:0]   path_count_o,
  output logic      [tpc_pkg::SumBits-1:0]        best_sum_o
);

  localparam int AddrBits = $clog2(MAX_ROWS);
  localparam int SumBits  = tpc_pkg::SumBits;
  localparam int MemBits  = SumBits + COUNT_BITS;

  logic [tpc_pkg::RowCfgBits-1:0] row_count_q;
  logic                           accept;
  logic                           stage_free;
  logic [AddrBits-1:0]            raddr, waddr;
  logic [MemBits-1:0]             rdata;
  logic [SumBits-1:0]             cell_best;
  logic [COUNT_BITS-1:0]          cell_cnt;
  tpc_pkg::tpc_ctl_t              cell_ctl;

  // Row count register; it takes effect for the next accepted cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= tpc_pkg::RowCfgBits'(1);
    end else if (row_count_we_i) begin
      row_count_q <= row_count_i;
    end
  end

  assign in_ready_o = stage_free;
  assign accept     = in_valid_i && in_ready_o;

  // The previous row's best sums and path counts, one entry per column.
  tpc_row_mem #(
    .Depth (MAX_ROWS),
    .Width (MemBits)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (waddr),
    .wdata_i ({cell_best, cell_cnt}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tpc_cell_stage #(
    .MaxRows   (MAX_ROWS),
    .ValueBits (VALUE_BITS),
    .CountBits (COUNT_BITS)
  ) u_cell_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cell_value_i (cell_value_i),
    .row_count_i  (row_count_q),
    .rd_sum_i     (rdata[MemBits-1:COUNT_BITS]),
    .rd_cnt_i     (rdata[COUNT_BITS-1:0]),
    .raddr_o      (raddr),
    .waddr_o      (waddr),
    .best_o       (cell_best),
    .cnt_o        (cell_cnt),
    .ctl_o        (cell_ctl)
  );

  tpc_final_stage #(
    .CountBits (COUNT_BITS)
  ) u_final_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .best_i       (cell_best),
    .cnt_i        (cell_cnt),
    .ctl_i        (cell_ctl),
    .out_ready_i  (out_ready_i),
    .free_o       (stage_free),
    .out_valid_o  (out_valid_o),
    .path_count_o (path_count_o),
    .best_sum_o   (best_sum_o)
  );

endmodule

`default_nettype wire

/* dv/tpc_path_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the triangle maximum path counter: watches the row count port
// and both item channels, predicts each result and compares it with the block.
// Depends on tpc_pkg for field widths and default parameter values.

module tpc_path_checker #(
  parameter int MAX_ROWS   = tpc_pkg::DefMaxRows,
  parameter int VALUE_BITS = tpc_pkg::DefValueBits,
  parameter int COUNT_BITS = tpc_pkg::DefCountBits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             row_count_we_i,
  input  logic [tpc_pkg::RowCfgBits-1:0]   row_count_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [VALUE_BITS-1:0]            cell_value_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [tpc_pkg::OutCountBits-1:0] path_count_i,
  input  logic [tpc_pkg::SumBits-1:0]      best_sum_i,
  output int                               fail_count_o,
  output int                               outstanding_o
);

  typedef logic [tpc_pkg::SumBits-1:0] sum_t;
  typedef logic [COUNT_BITS-1:0]       paths_t;

  typedef struct {
    logic [tpc_pkg::OutCountBits-1:0] paths;
    sum_t                             sum;
  } tri_result_t;

  // Shadow of the previous row plus the running position and last-row maximum.
  sum_t                             prev_row_sum   [MAX_ROWS];
  paths_t                           prev_row_paths [MAX_ROWS];
  sum_t                             carry_sum;
  paths_t                           carry_paths;
  int unsigned                      cur_row;
  int unsigned                      cur_col;
  sum_t                             peak_sum;
  paths_t                           peak_paths;
  logic [tpc_pkg::RowCfgBits-1:0]   rows_reg;
  tri_result_t                      expected_q [$];
  tri_result_t                      head;

  function automatic sum_t sat_sum(input sum_t a, input sum_t b);
    logic [tpc_pkg::SumBits:0] wide;
    wide = a + b;
    return (wide >= tpc_pkg::SumMax) ? tpc_pkg::SumMax : wide[tpc_pkg::SumBits-1:0];
  endfunction

  function automatic paths_t sat_paths(input paths_t a, input paths_t b);
    logic [COUNT_BITS:0] wide;
    wide = a + b;
    return wide[COUNT_BITS] ? '1 : wide[COUNT_BITS-1:0];
  endfunction

  // Folds one accepted cell into the shadow state and queues the triangle's
  // result when the cell closes it.
  function automatic void tally_cell(input logic [VALUE_BITS-1:0] value);
    sum_t        v, up_sum, par_sum, best;
    paths_t      up_paths, par_paths, paths;
    bit          has_left, has_up, last_row;
    int unsigned r, c, rows;
    tri_result_t res;
    r = cur_row;
    c = cur_col;
    if (VALUE_BITS > tpc_pkg::SumBits && value > tpc_pkg::SumMax) v = tpc_pkg::SumMax;
    else v = sum_t'(value);

    if (r == 0 || r >= MAX_ROWS || c >= MAX_ROWS) begin
      best  = v;
      paths = paths_t'(1);
      r     = 0;
      c     = 0;
    end else begin
      has_left = (c >= 1);
      has_up   = (c < r);
      up_sum   = has_up ? prev_row_sum[c] : '0;
      up_paths = has_up ? prev_row_paths[c] : '0;
      if (has_left && has_up) begin
        if (carry_sum > up_sum) begin
          par_sum   = carry_sum;
          par_paths = carry_paths;
        end else if (up_sum > carry_sum) begin
          par_sum   = up_sum;
          par_paths = up_paths;
        end else begin
          par_sum   = up_sum;
          par_paths = sat_paths(carry_paths, up_paths);
        end
      end else if (has_left) begin
        par_sum   = carry_sum;
        par_paths = carry_paths;
      end else begin
        par_sum   = up_sum;
        par_paths = up_paths;
      end
      best        = sat_sum(par_sum, v);
      paths       = par_paths;
      carry_sum   = up_sum;
      carry_paths = up_paths;
    end

    prev_row_sum[c]   = best;
    prev_row_paths[c] = paths;

    if (rows_reg == 0) rows = 1;
    else if (rows_reg > MAX_ROWS) rows = MAX_ROWS;
    else rows = 32'(rows_reg);
    last_row = (r + 1 >= rows);

    if (last_row) begin
      if (c == 0 || best > peak_sum) begin
        peak_sum   = best;
        peak_paths = paths;
      end else if (best == peak_sum) begin
        peak_paths = sat_paths(peak_paths, paths);
      end
    end

    if (c >= r) begin
      cur_col = 0;
      if (last_row) begin
        cur_row   = 0;
        res.paths = peak_paths[tpc_pkg::OutCountBits-1:0];
        res.sum   = peak_sum;
        expected_q.push_back(res);
      end else begin
        cur_row = r + 1;
      end
    end else begin
      cur_col = c + 1;
      cur_row = r;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_reg      = tpc_pkg::RowCfgBits'(1);
      carry_sum     = '0;
      carry_paths   = '0;
      cur_row       = 0;
      cur_col       = 0;
      peak_sum      = '0;
      peak_paths    = '0;
      fail_count_o  = 0;
      outstanding_o = 0;
      expected_q.delete();
    end else begin
      if (row_count_we_i) rows_reg = row_count_i;
      if (in_valid_i && in_ready_i) tally_cell(cell_value_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with none expected: path_count %0d best_sum %0d",
                   $time, path_count_i, best_sum_i);
        end else begin
          head = expected_q.pop_front();
          if (path_count_i !== head.paths) begin
            fail_count_o++;
            $display("%0t: path_count expected %0d, actual %0d",
                     $time, head.paths, path_count_i);
          end
          if (best_sum_i !== head.sum) begin
            fail_count_o++;
            $display("%0t: best_sum expected %0d, actual %0d",
                     $time, head.sum, best_sum_i);
          end
        end
      end
      outstanding_o = expected_q.size();
    end
  end

endmodule

/* dv/tb_triangle_max_path_counter.sv */
`timescale 1ns / 100ps
// Top of the triangle maximum path counter testbench: clock, reset, stimulus
// and verdict. Uses tpc_pkg, the block under test and tpc_path_checker.

module tb_triangle_max_path_counter;

  localparam int MaxRows    = tpc_pkg::DefMaxRows;
  localparam int ValueBits  = tpc_pkg::DefValueBits;
  localparam int CycleLimit = 1000000;
  // Extra wait after the last expected result has left the block.
  localparam int SettleCycles = 4;
  localparam int HoldCycles   = 300;

  // How the values of one triangle are drawn.
  typedef enum int {
    VAL_FULL,    // any 20-bit value, so every bit toggles
    VAL_NARROW,  // 0 to 3, so ties between parents and in the last row are common
    VAL_FLAT,    // one value for every cell, so all paths tie
    VAL_PEAK     // all ones everywhere
  } value_mode_e;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           row_count_we = 1'b0;
  logic [tpc_pkg::RowCfgBits-1:0] row_count = '0;
  logic                           in_valid = 1'b0;
  logic [ValueBits-1:0]           cell_value = '0;
  logic                           out_ready = 1'b0;
  logic                           in_ready;
  logic                           out_valid;
  logic [tpc_pkg::OutCountBits-1:0] path_count;
  logic [tpc_pkg::SumBits-1:0]    best_sum;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int sent_cells = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_off_req = 1'b0;
  bit hold_started = 1'b0;
  int hold_left = 0;

  always #6 clk_i = ~clk_i;

  triangle_max_path_counter DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .row_count_we_i (row_count_we),
    .row_count_i    (row_count),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cell_value_i   (cell_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .path_count_o   (path_count),
    .best_sum_o     (best_sum)
  );

  tpc_path_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .row_count_we_i (row_count_we),
    .row_count_i    (row_count),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .cell_value_i   (cell_value),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .path_count_i   (path_count),
    .best_sum_i     (best_sum),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding)
  );

  // Watchdog. The limit covers the largest triangles at full sender gaps and
  // receiver stalls several times over.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side. A long hold-off is requested once by the stimulus; this
  // process owns the counter so that the request is the only shared write.
  // Otherwise ready drops at random at the rate of the current phase.
  always @(posedge clk_i) begin
    if (hold_off_req && !hold_started) begin
      hold_started = 1'b1;
      hold_left    = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic [ValueBits-1:0] pick_value(input value_mode_e mode,
                                                      input logic [ValueBits-1:0] flat);
    case (mode)
      VAL_FULL:   return ValueBits'($urandom);
      VAL_NARROW: return ValueBits'($urandom_range(3));
      VAL_FLAT:   return flat;
      default:    return '1;
    endcase
  endfunction

  function automatic value_mode_e pick_mode();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) return VAL_FULL;
    if (sel < 8) return VAL_NARROW;
    if (sel < 9) return VAL_FLAT;
    return VAL_PEAK;
  endfunction

  // Offers one cell. A gap, if any, comes before the item; valid stays high
  // across back-to-back items so it is assigned once per edge.
  task automatic send_cell(input logic [ValueBits-1:0] value);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    cell_value <= value;
    do @(posedge clk_i); while (!in_ready);
    sent_cells++;
  endtask

  // Stops offering and waits until every expected result has left the block.
  // The first edge lets the checker count a cell accepted at the last edge.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // The row count is only written with the block idle, between triangles.
  task automatic set_rows(input int rows);
    settle();
    row_count_we <= 1'b1;
    row_count    <= tpc_pkg::RowCfgBits'(rows);
    @(posedge clk_i);
    row_count_we <= 1'b0;
  endtask

  task automatic send_triangle(input int rows, input value_mode_e mode);
    int eff;
    logic [ValueBits-1:0] flat;
    if (rows == 0) eff = 1;
    else if (rows > MaxRows) eff = MaxRows;
    else eff = rows;
    flat = ValueBits'($urandom);
    for (int i = 0; i < eff * (eff + 1) / 2; i++) send_cell(pick_value(mode, flat));
  endtask

  // Groups of triangles of one size flow back to back, so a result often
  // waits while the next triangle streams in. Sizes stay small.
  task automatic run_phase(input int tx_pct, input int rx_pct, input int budget);
    int start;
    int rows;
    int sel;
    int reps;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = sent_cells;
    while (sent_cells - start < budget) begin
      sel = $urandom_range(99);
      if (sel < 5) rows = 0;
      else if (sel < 70) rows = $urandom_range(1, 6);
      else rows = $urandom_range(7, 16);
      set_rows(rows);
      reps = (rows > 8) ? $urandom_range(1, 2) : $urandom_range(1, 6);
      repeat (reps) send_triangle(rows, pick_mode());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 11;
    rx_idle_pct = 57;

    // Reset row count of one: every cell is a triangle. Value extremes first.
    send_cell('0);
    send_cell('1);
    // A row count of zero also means one row.
    set_rows(0);
    send_cell(ValueBits'(20'h55555));
    send_cell(ValueBits'(20'hAAAAA));
    // Two rows whose last row ties: best 8 reached twice.
    set_rows(2);
    send_cell(ValueBits'(5));
    send_cell(ValueBits'(3));
    send_cell(ValueBits'(3));
    // Three rows where the middle cell's parents tie, so the counts add.
    set_rows(3);
    send_cell(ValueBits'(1));
    send_cell(ValueBits'(2));
    send_cell(ValueBits'(2));
    repeat (3) send_cell(ValueBits'(7));
    // Four rows of random values mix left-wins and up-wins parents.
    set_rows(4);
    send_triangle(4, VAL_FULL);

    // All-ones cells over 34 rows: every path ties, so the path count runs
    // past the 32-bit limit and saturates.
    set_rows(34);
    send_triangle(34, VAL_PEAK);

    run_phase(11, 57, 350);
    run_phase(57, 11, 350);

    // Receiver holds off for a long stretch while one-row triangles keep
    // coming with no gaps, so the block must stall its input. The sender then
    // pauses until every result has come out.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_rows(1);
    hold_off_req = 1'b1;
    repeat (40) send_cell(ValueBits'($urandom));
    settle();

    run_phase(0, 0, 350);
    settle();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/tpc_pkg.sv
design/tpc_row_mem.sv
design/tpc_cell_stage.sv
design/tpc_final_stage.sv
design/triangle_max_path_counter.sv
dv/tpc_path_checker.sv
dv/tb_triangle_max_path_counter.sv
